// File: hw/rtl/ssmp_pkg.sv
// shared types, constants and the microcode program of the servo smoothstep profile
// used by every module of the block; depends on nothing
`default_nettype none

package ssmp_pkg;

   // field widths
   localparam int ANGLE_W = 14;
   localparam int TICK_W  = 16;
   localparam int DUTY_W  = 16;
   localparam int FRAC_W  = 16;

   // datapath widths
   localparam int ACC_W  = 33;
   localparam int MULA_W = 31;
   localparam int MULB_W = 24;
   localparam int PROD_W = MULA_W + MULB_W;

   // full angle of 180 degrees in 1/64 degree, scaled by 2^FRAC_W:
   // 11520 * 2^16 = 45 * 2^24, so the scale divide is a shift by 24 and a divide by 45;
   // the divide by 45 is a multiply by ceil(2^28 / 45) and a shift by 28, exact below 2^22
   localparam logic [ACC_W-1:0] SCALE_TOP   = 33'd754974720;
   localparam int               SCALE_SHIFT = 24;
   localparam logic [22:0]      RECIP_45    = 23'd5965233;
   localparam int               RECIP_SHIFT = 28;

   // register reset values and map
   localparam logic [DUTY_W-1:0] DUTY_ZERO_RESET = 16'd1638;
   localparam logic [DUTY_W-1:0] DUTY_FULL_RESET = 16'd8192;
   localparam logic              REG_DUTY_ZERO   = 1'b0;
   localparam logic              REG_DUTY_FULL   = 1'b1;

   // input kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_TICK  = 1'b1;

   typedef logic [3:0] step_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_DIV_P,
      OP_MUL_SQ,
      OP_MUL_EASE,
      OP_MUL_DELTA,
      OP_SUM,
      OP_CLAMP,
      OP_MUL_SCALE,
      OP_MUL_RECIP,
      OP_DUTY
   } dp_op_type;

   typedef enum logic [1:0] {
      COND_NEXT,
      COND_FIXED,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } jump_cond_type;

   typedef struct packed {
      dp_op_type     op;
      jump_cond_type cond;
      step_type      target;
      logic          last;
   } ucode_type;

   // control from sequencer to datapath
   typedef struct packed {
      dp_op_type op;
      logic      fire;
   } dp_ctrl_type;

   // program steps
   localparam step_type S_ENTRY  = 4'd0;
   localparam step_type S_DIV_P  = 4'd1;
   localparam step_type S_WAIT_P = 4'd2;
   localparam step_type S_SQ     = 4'd3;
   localparam step_type S_EASE   = 4'd4;
   localparam step_type S_DELTA  = 4'd5;
   localparam step_type S_SUM    = 4'd6;
   localparam step_type S_CLAMP  = 4'd7;
   localparam step_type S_SCALE  = 4'd8;
   localparam step_type S_RECIP  = 4'd9;
   localparam step_type S_DUTY   = 4'd10;

   // microcode rom
   function automatic ucode_type ucode_word(input step_type step);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_NEXT, target: S_ENTRY, last: 1'b0};
      case (step)
         S_ENTRY:  w = '{op: OP_NOP,       cond: COND_FIXED,    target: S_CLAMP, last: 1'b0};
         S_DIV_P:  w = '{op: OP_DIV_P,     cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_WAIT_P: w = '{op: OP_NOP,       cond: COND_DIV_BUSY, target: S_ENTRY, last: 1'b0};
         S_SQ:     w = '{op: OP_MUL_SQ,    cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_EASE:   w = '{op: OP_MUL_EASE,  cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_DELTA:  w = '{op: OP_MUL_DELTA, cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_SUM:    w = '{op: OP_SUM,       cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_CLAMP:  w = '{op: OP_CLAMP,     cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_SCALE:  w = '{op: OP_MUL_SCALE, cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_RECIP:  w = '{op: OP_MUL_RECIP, cond: COND_NEXT,     target: S_ENTRY, last: 1'b0};
         S_DUTY:   w = '{op: OP_DUTY,      cond: COND_OUT_BUSY, target: S_ENTRY, last: 1'b1};
         default:  w = '{op: OP_NOP,       cond: COND_NEXT,     target: S_ENTRY, last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/servo_smoothstep_motion_profile.sv
// Servo smoothstep move generator. A start item (tuser 0) loads a move toward a
// target angle in 1/64 degree over a number of 1 ms ticks; each tick item (tuser 1)
// returns one item with the eased, clamped angle mapped to a PWM duty and a moving
// flag. Every input item gives exactly one result item. Items are handled one at a
// time by a microcoded sequencer over a shared multiplier and a 16-step serial
// divider: a tick inside a move runs an entry step, a progress divide that holds the
// program until the divider is done, eight multiply, add, clamp and duty steps, and
// then frees the input for the next item; start items, idle ticks and the final tick
// of a move need no divide and go from the entry step straight to the clamp, scale,
// reciprocal and duty steps. The scaling by the full angle is a multiply by a
// reciprocal. A result that cannot leave holds the program at its duty step; a
// finished result waits in the output register while the next item is accepted.
// Depends on ssmp_pkg, ssmp_sequencer, ssmp_datapath.
`default_nettype none

module servo_smoothstep_motion_profile
   import ssmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // target_angle[13:0], duration_ms[29:14], zero
   input  wire logic        req_tuser,   // kind
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // duty[15:0]
   output logic             rsp_tuser,   // moving
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [DUTY_W-1:0]  duty_zero_ff, duty_zero_in;
   logic [DUTY_W-1:0]  duty_full_ff, duty_full_in;
   logic [ANGLE_W-1:0] finished_ff, finished_in;
   logic [ANGLE_W-1:0] move_start_ff, move_start_in;
   logic [ANGLE_W-1:0] move_target_ff, move_target_in;
   logic [TICK_W-1:0]  elapsed_ff, elapsed_in;
   logic [TICK_W-1:0]  length_ff, length_in;
   logic               busy_ff, busy_in;
   logic               angle_only_ff, angle_only_in;
   logic               moving_ff, moving_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DUTY_W-1:0]  rsp_duty_ff, rsp_duty_in;
   logic               rsp_moving_ff, rsp_moving_in;

   logic               accept;
   logic               running;
   logic               div_busy;
   logic               out_blocked;
   logic               duty_done;
   logic [DUTY_W-1:0]  dp_duty;
   logic [ANGLE_W-1:0] load_angle;
   logic [ANGLE_W-1:0] req_target;
   logic [TICK_W-1:0]  req_duration;
   logic [TICK_W-1:0]  elapsed_next;
   logic               csr_write;
   dp_ctrl_type        ctrl;

   assign req_target   = req_tdata[ANGLE_W-1:0];
   assign req_duration = req_tdata[ANGLE_W+TICK_W-1:ANGLE_W];
   assign req_tready   = !running;
   assign accept       = req_tvalid && req_tready;
   assign out_blocked  = rsp_valid_ff && !rsp_tready;
   assign duty_done    = ctrl.fire && ctrl.op == OP_DUTY;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      duty_zero_in = duty_zero_ff;
      duty_full_in = duty_full_ff;
      if (csr_write) begin
         if (csr_paddr[2] == REG_DUTY_ZERO) begin
            duty_zero_in = csr_pwdata[DUTY_W-1:0];
         end else begin
            duty_full_in = csr_pwdata[DUTY_W-1:0];
         end
      end
      csr_prdata = (csr_paddr[2] == REG_DUTY_ZERO) ? {16'b0, duty_zero_ff}
                                                   : {16'b0, duty_full_ff};
   end

   // move state, updated when an item is accepted
   always_comb begin
      finished_in    = finished_ff;
      move_start_in  = move_start_ff;
      move_target_in = move_target_ff;
      elapsed_in     = elapsed_ff;
      length_in      = length_ff;
      busy_in        = busy_ff;
      angle_only_in  = angle_only_ff;
      moving_in      = moving_ff;
      load_angle     = finished_ff;
      elapsed_next   = TICK_W'(elapsed_ff + 16'd1);
      if (accept) begin
         if (req_tuser == KIND_START) begin
            move_start_in  = finished_ff;
            move_target_in = req_target;
            length_in      = req_duration;
            elapsed_in     = '0;
            angle_only_in  = 1'b1;
            if (req_duration == '0) begin
               finished_in = req_target;
               busy_in     = 1'b0;
               load_angle  = req_target;
               moving_in   = 1'b0;
            end else begin
               busy_in    = 1'b1;
               load_angle = finished_ff;
               moving_in  = 1'b1;
            end
         end else if (!busy_ff || length_ff == '0) begin
            // idle tick
            busy_in       = 1'b0;
            angle_only_in = 1'b1;
            load_angle    = finished_ff;
            moving_in     = 1'b0;
         end else begin
            elapsed_in = elapsed_next;
            if (elapsed_next >= length_ff) begin
               finished_in   = move_target_ff;
               busy_in       = 1'b0;
               angle_only_in = 1'b1;
               load_angle    = move_target_ff;
               moving_in     = 1'b0;
            end else begin
               angle_only_in = 1'b0;
               moving_in     = 1'b1;
            end
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_moving_in = rsp_moving_ff;
      if (duty_done) begin
         rsp_valid_in  = 1'b1;
         rsp_duty_in   = dp_duty;
         rsp_moving_in = moving_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_zero_ff   <= DUTY_ZERO_RESET;
         duty_full_ff   <= DUTY_FULL_RESET;
         finished_ff    <= '0;
         move_start_ff  <= '0;
         move_target_ff <= '0;
         elapsed_ff     <= '0;
         length_ff      <= '0;
         busy_ff        <= 1'b0;
         angle_only_ff  <= 1'b1;
         moving_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         duty_zero_ff   <= duty_zero_in;
         duty_full_ff   <= duty_full_in;
         finished_ff    <= finished_in;
         move_start_ff  <= move_start_in;
         move_target_ff <= move_target_in;
         elapsed_ff     <= elapsed_in;
         length_ff      <= length_in;
         busy_ff        <= busy_in;
         angle_only_ff  <= angle_only_in;
         moving_ff      <= moving_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_duty_ff   <= rsp_duty_in;
      rsp_moving_ff <= rsp_moving_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_duty_ff;
   assign rsp_tuser  = rsp_moving_ff;

   ssmp_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .angle_only  (angle_only_in),
      .div_busy    (div_busy),
      .out_blocked (out_blocked),
      .running     (running),
      .ctrl        (ctrl)
   );

   ssmp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .load_en    (accept),
      .load_angle (load_angle),
      .elapsed    (elapsed_ff),
      .length     (length_ff),
      .start_pos  (move_start_ff),
      .target_pos (move_target_ff),
      .duty_zero  (duty_zero_ff),
      .duty_full  (duty_full_ff),
      .div_busy   (div_busy),
      .duty       (dp_duty)
   );

endmodule

`default_nettype wire

// File: hw/rtl/ssmp_divider.sv
// restoring serial divider, one quotient bit per cycle, 16-bit quotient
// uses ssmp_pkg; the high half of the dividend must be below the divisor
`default_nettype none

module ssmp_divider
   import ssmp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend_hi,
   input  wire logic [15:0] dividend_lo,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [15:0]      quotient
);

   logic        busy_ff, busy_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quot_ff, quot_in;
   logic [15:0] div_ff, div_in;
   logic [16:0] trial;
   logic        fits;

   // one shift-and-subtract step
   always_comb begin
      trial    = {rem_ff, quot_ff[15]};
      fits     = trial >= {1'b0, div_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = dividend_hi;
         quot_in  = dividend_lo;
         div_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
         quot_in  = {quot_ff[14:0], fits};
         count_in = 4'(count_ff + 4'd1);
         if (count_ff == 4'd15) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      div_ff  <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

// File: hw/rtl/ssmp_datapath.sv
// datapath: shared multiplier, product and accumulator registers, serial divider
// uses ssmp_pkg and ssmp_divider; driven one operation per cycle by the sequencer while it does not hold a step
`default_nettype none

module ssmp_datapath
   import ssmp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_ctrl_type        ctrl,
   input  wire logic               load_en,
   input  wire logic [ANGLE_W-1:0] load_angle,
   input  wire logic [TICK_W-1:0]  elapsed,
   input  wire logic [TICK_W-1:0]  length,
   input  wire logic [ANGLE_W-1:0] start_pos,
   input  wire logic [ANGLE_W-1:0] target_pos,
   input  wire logic [DUTY_W-1:0]  duty_zero,
   input  wire logic [DUTY_W-1:0]  duty_full,
   output logic                    div_busy,
   output logic [DUTY_W-1:0]       duty
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [MULA_W-1:0] mul_a;
   logic signed [MULB_W-1:0] mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [ANGLE_W:0]  delta;
   logic [17:0]              ease_factor;
   logic signed [DUTY_W:0]   span;
   logic                     span_neg;
   logic [DUTY_W-1:0]        mag;
   logic [DUTY_W-1:0]        scale_q;
   logic                     div_start;
   logic [15:0]              div_hi, div_lo, div_den;
   logic [15:0]              quot;
   logic                     is_fire_mul;

   // duty span from the two registers
   always_comb begin
      span     = $signed({1'b0, duty_full}) - $signed({1'b0, duty_zero});
      span_neg = span[DUTY_W];
      mag      = span_neg ? DUTY_W'(-span) : span[DUTY_W-1:0];
   end

   // operand selection for the shared multiplier
   always_comb begin
      delta       = $signed({1'b0, target_pos}) - $signed({1'b0, start_pos});
      ease_factor = (18'd3 << FRAC_W) - {1'b0, quot, 1'b0};
      mul_a       = '0;
      mul_b       = '0;
      case (ctrl.op)
         OP_MUL_SQ: begin
            mul_a = {15'b0, quot};
            mul_b = {8'b0, quot};
         end
         OP_MUL_EASE: begin
            mul_a = {15'b0, prod_ff[31:16]};
            mul_b = {6'b0, ease_factor};
         end
         OP_MUL_DELTA: begin
            mul_a = {{(MULA_W-ANGLE_W-1){delta[ANGLE_W]}}, delta};
            mul_b = {7'b0, prod_ff[32:16]};
         end
         OP_MUL_SCALE: begin
            mul_a = {1'b0, acc_ff[29:0]};
            mul_b = {8'b0, mag};
         end
         OP_MUL_RECIP: begin
            // scaled product over 2^24, times the reciprocal of 45
            mul_a = {9'b0, prod_ff[SCALE_SHIFT+21:SCALE_SHIFT]};
            mul_b = {1'b0, RECIP_45};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      product = mul_a * mul_b;
   end

   // register updates
   always_comb begin
      is_fire_mul = ctrl.fire && (ctrl.op == OP_MUL_SQ || ctrl.op == OP_MUL_EASE ||
                                  ctrl.op == OP_MUL_DELTA || ctrl.op == OP_MUL_SCALE ||
                                  ctrl.op == OP_MUL_RECIP);
      prod_in = is_fire_mul ? product : prod_ff;
      acc_in  = acc_ff;
      if (load_en) begin
         acc_in = $signed({3'b0, load_angle, 16'b0});
      end else if (ctrl.fire && ctrl.op == OP_SUM) begin
         acc_in = $signed({3'b0, start_pos, 16'b0}) + $signed(prod_ff[ACC_W-1:0]);
      end else if (ctrl.fire && ctrl.op == OP_CLAMP) begin
         if (acc_ff[ACC_W-1]) begin
            acc_in = '0;
         end else if ($unsigned(acc_ff) > SCALE_TOP) begin
            acc_in = $signed(SCALE_TOP);
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // divider operands: progress as elapsed * 2^16 / length
   always_comb begin
      div_start = ctrl.fire && ctrl.op == OP_DIV_P;
      div_hi    = elapsed;
      div_lo    = '0;
      div_den   = length;
   end

   ssmp_divider u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .dividend_hi (div_hi),
      .dividend_lo (div_lo),
      .divisor     (div_den),
      .busy        (div_busy),
      .quotient    (quot)
   );

   // final duty from the scaled quotient, wraps to 16 bits
   assign scale_q = prod_ff[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
   assign duty    = span_neg ? DUTY_W'(duty_zero - scale_q) : DUTY_W'(duty_zero + scale_q);

endmodule

`default_nettype wire

// File: hw/rtl/ssmp_sequencer.sv
// microcode sequencer: step counter over the program rom with conditional jumps
// uses ssmp_pkg for the control word and step names
`default_nettype none

module ssmp_sequencer
   import ssmp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  start,
   input  wire logic  angle_only,
   input  wire logic  div_busy,
   input  wire logic  out_blocked,
   output logic       running,
   output dp_ctrl_type ctrl
);

   logic      running_ff, running_in;
   step_type  step_ff, step_in;
   ucode_type word;
   logic      hold;

   // decode the current control word
   always_comb begin
      word = ucode_word(step_ff);
      hold = (word.cond == COND_DIV_BUSY && div_busy) ||
             (word.cond == COND_OUT_BUSY && out_blocked);
      ctrl.op   = word.op;
      ctrl.fire = running_ff && !hold;
   end

   // next step
   always_comb begin
      running_in = running_ff;
      step_in    = step_ff;
      if (!running_ff) begin
         if (start) begin
            running_in = 1'b1;
            step_in    = S_ENTRY;
         end
      end else if (!hold) begin
         if (word.last) begin
            running_in = 1'b0;
         end else if (word.cond == COND_FIXED && angle_only) begin
            step_in = word.target;
         end else begin
            step_in = step_type'(step_ff + 4'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         step_ff    <= S_ENTRY;
      end else begin
         running_ff <= running_in;
         step_ff    <= step_in;
      end
   end

   assign running = running_ff;

endmodule

`default_nettype wire
